// ----- hdl/wnr_pkg.sv -----
package wnr_pkg;

  localparam int LIMB_W        = 64;
  localparam int DIGIT_W       = 17;
  localparam int WIN_W         = 5;
  localparam int WIN_MAX       = 16;
  localparam int WIN_RESET     = 2;
  localparam int LIMB_SEL_W    = 2;
  localparam int NUM_LIMBS_DEF = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EMIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // control from the sequencer to the limb store
  typedef struct packed {
    logic clr;
    logic wr_en;
  } store_ctl_t;

endpackage

// ----- hdl/wnr_ifs.sv -----
interface wnr_cmd_if import wnr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [LIMB_SEL_W-1:0] limb_index;
  logic [LIMB_W-1:0]     limb_value;

  modport source (output valid, output op, output limb_index, output limb_value, input ready);
  modport sink (input valid, input op, input limb_index, input limb_value, output ready);
endinterface

interface wnr_res_if import wnr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DIGIT_W-1:0] digit;
  logic                      is_last;
  logic                      exhausted;

  modport source (output valid, output digit, output is_last, output exhausted, input ready);
  modport sink (input valid, input digit, input is_last, input exhausted, output ready);
endinterface

// ----- hdl/wnr_limb_store.sv -----
module wnr_limb_store import wnr_pkg::*; #(
  parameter int NUM_LIMBS = NUM_LIMBS_DEF,
  parameter int IDX_W     = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  store_ctl_t        ctl,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [LIMB_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [LIMB_W-1:0] rd_data,
  output logic [15:0]       low_bits,
  output logic              any_nz
);

  logic [LIMB_W-1:0]    limbs [NUM_LIMBS];
  logic [NUM_LIMBS-1:0] nz;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      limbs[wr_addr] <= wr_data;
    end
  end

  // a limb whose flag is low reads as zero, so clear needs no sweep
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      nz <= '0;
    end else if (ctl.wr_en) begin
      nz[wr_addr] <= |wr_data;
    end
  end

  assign rd_data  = nz[rd_addr] ? limbs[rd_addr] : '0;
  assign low_bits = nz[0] ? limbs[0][15:0] : 16'd0;
  assign any_nz   = |nz;

endmodule

// ----- hdl/wnr_step_alu.sv -----
module wnr_step_alu import wnr_pkg::*; (
  input  logic [LIMB_W-1:0]  a,
  input  logic [DIGIT_W-1:0] c,
  input  logic               sub,
  output logic [LIMB_W-1:0]  s,
  output logic               c_out
);

  logic [LIMB_W:0] ext_c;
  logic [LIMB_W:0] sum;

  assign ext_c = {{(LIMB_W + 1 - DIGIT_W){1'b0}}, c};
  // top bit is the carry on add and the borrow on subtract
  assign sum   = sub ? ({1'b0, a} - ext_c) : ({1'b0, a} + ext_c);
  assign s     = sum[LIMB_W-1:0];
  assign c_out = sum[LIMB_W];

endmodule

// ----- hdl/wnaf_scalar_recoder.sv -----
// Clear and load items finish in idle; an emit on a zero value is answered from idle.
// An emit with a nonzero value is busy through accept, digit setup, a pass for each limb
// through the shared add/subtract-and-shift step, and the top limb write.
// The result register holds one item; a new item is taken once it is free or being taken.
// rst is synchronous, active high: value reads zero, window is 2, no result pending.
module wnaf_scalar_recoder import wnr_pkg::*; #(
  parameter int NUM_LIMBS = NUM_LIMBS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  wnr_cmd_if.sink          cmd,
  wnr_res_if.source        res
);

  localparam int IDX_W = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_LIMBS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PREP  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_TOP   = 4'b1000
  } state_t;

  state_t               state;
  logic [WIN_W-1:0]     window;
  logic                 headroom;
  logic [IDX_W-1:0]     cnt;
  logic [DIGIT_W-1:0]   carry;
  logic                 sub_mode;
  logic [LIMB_W-1:0]    prev;
  logic                 acc;
  logic [DIGIT_W-1:0]   digit_hold;
  logic                 ov;
  logic signed [DIGIT_W-1:0] digit_out;
  logic                 last_out;
  logic                 exh_out;

  logic                 accept;
  logic                 is_zero;
  store_ctl_t           ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [LIMB_W-1:0]    wr_data;
  logic [LIMB_W-1:0]    rd_data;
  logic [15:0]          low_bits;
  logic                 any_nz;
  logic [LIMB_W-1:0]    alu_s;
  logic                 alu_c;

  logic [WIN_W-1:0]     wc;
  logic [DIGIT_W-1:0]   full;
  logic [DIGIT_W-1:0]   half;
  logic [DIGIT_W-1:0]   low;
  logic [DIGIT_W-1:0]   mag;
  logic                 load_ok;
  logic [LIMB_W-1:0]    top_data;
  logic [LIMB_W-1:0]    shift_data;

  assign cmd.ready = (state == S_IDLE) && (!ov || res.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign is_zero   = !any_nz && !headroom;
  assign load_ok   = 32'(cmd.limb_index) < NUM_LIMBS;

  // clamp window to 1..16 and split the low bits
  always_comb begin
    if (window == '0) begin
      wc = WIN_W'(1);
    end else if (window > WIN_W'(WIN_MAX)) begin
      wc = WIN_W'(WIN_MAX);
    end else begin
      wc = window;
    end
    full = DIGIT_W'(1) << wc;
    half = DIGIT_W'(1) << (wc - WIN_W'(1));
    low  = {1'b0, low_bits} & (full - DIGIT_W'(1));
    mag  = full - low;
  end

  wnr_step_alu u_alu (
    .a     (rd_data),
    .c     (carry),
    .sub   (sub_mode),
    .s     (alu_s),
    .c_out (alu_c)
  );

  assign shift_data = {alu_s[0], prev[LIMB_W-1:1]};
  assign top_data   = {headroom ^ carry[0], prev[LIMB_W-1:1]};

  always_comb begin
    ctl.clr   = accept && (op_t'(cmd.op) == OP_CLEAR);
    ctl.wr_en = 1'b0;
    wr_addr   = IDX_W'(cmd.limb_index);
    wr_data   = cmd.limb_value;
    case (state)
      S_IDLE: begin
        ctl.wr_en = accept && (op_t'(cmd.op) == OP_LOAD) && load_ok;
      end
      S_SWEEP: begin
        ctl.wr_en = (cnt != '0);
        wr_addr   = cnt - IDX_W'(1);
        wr_data   = shift_data;
      end
      S_TOP: begin
        ctl.wr_en = 1'b1;
        wr_addr   = LAST;
        wr_data   = top_data;
      end
      default: begin
        ctl.wr_en = 1'b0;
      end
    endcase
  end

  wnr_limb_store #(
    .NUM_LIMBS (NUM_LIMBS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (cnt),
    .rd_data  (rd_data),
    .low_bits (low_bits),
    .any_nz   (any_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WIN_W'(WIN_RESET);
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      headroom <= 1'b0;
      ov       <= 1'b0;
    end else begin
      if (res.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (op_t'(cmd.op) == OP_CLEAR)) begin
            headroom <= 1'b0;
          end else if (accept && (op_t'(cmd.op) == OP_EMIT)) begin
            if (is_zero) begin
              ov <= 1'b1;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (cnt == LAST) begin
            state <= S_TOP;
          end
        end
        S_TOP: begin
          headroom <= 1'b0;
          ov       <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // load the exhausted answer only when a zero-value emit is taken
        if (accept && (op_t'(cmd.op) == OP_EMIT) && is_zero) begin
          digit_out <= '0;
          last_out  <= 1'b0;
          exh_out   <= 1'b1;
        end
      end
      S_PREP: begin
        cnt <= '0;
        acc <= 1'b0;
        if (!low_bits[0]) begin
          sub_mode   <= 1'b0;
          carry      <= '0;
          digit_hold <= '0;
        end else if (low > half) begin
          sub_mode   <= 1'b0;
          carry      <= mag;
          digit_hold <= DIGIT_W'(0) - mag;
        end else begin
          sub_mode   <= 1'b1;
          carry      <= low;
          digit_hold <= low;
        end
      end
      S_SWEEP: begin
        carry <= {{(DIGIT_W - 1){1'b0}}, alu_c};
        prev  <= alu_s;
        if (cnt != '0) begin
          acc <= acc | (|shift_data);
        end
        if (cnt != LAST) begin
          cnt <= cnt + IDX_W'(1);
        end
      end
      S_TOP: begin
        digit_out <= digit_hold;
        last_out  <= !(acc | (|top_data));
        exh_out   <= 1'b0;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign res.valid     = ov;
  assign res.digit     = digit_out;
  assign res.is_last   = last_out;
  assign res.exhausted = exh_out;

  // an exhausted answer carries no digit and no last flag
  a_exh_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.exhausted |-> (res.digit == '0) && !res.is_last)
    else $error("exhausted result with digit or last flag");

  // every nonzero digit is odd
  a_digit_odd: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.digit != '0) |-> res.digit[0])
    else $error("even nonzero digit");

  // the headroom bit is spent by the halving before the block goes idle
  a_headroom: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_TOP |-> !headroom && (state == S_IDLE))
    else $error("headroom left after a digit step");

endmodule
